@@ rtl/rgb2hsv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2hsv_pkg
// Shared widths and types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

   localparam int CH_W  = 8;
   localparam int HUE_W = 15;
   localparam int SAT_W = 17;
   localparam int VAL_W = 8;
   localparam int DEN_W = CH_W + 1;
   localparam int TOP_W = CH_W + 3;
   localparam int BASE_W = 3;

   typedef logic [CH_W-1:0]  chan_type;
   typedef logic [HUE_W-1:0] hue_type;
   typedef logic [SAT_W-1:0] sat_type;
   typedef logic [VAL_W-1:0] val_type;

endpackage

@@ rtl/rgb2hsv_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2hsv_req_if
// Pixel channel: one RGB pixel per beat.
// ----------------------------------------------------------------------------
interface rgb2hsv_req_if;
   logic                  valid;
   logic                  ready;
   rgb2hsv_pkg::chan_type red;
   rgb2hsv_pkg::chan_type green;
   rgb2hsv_pkg::chan_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

@@ rtl/rgb2hsv_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2hsv_rsp_if
// Result channel: one HSV triple per beat.
// ----------------------------------------------------------------------------
interface rgb2hsv_rsp_if;
   logic                 valid;
   logic                 ready;
   rgb2hsv_pkg::hue_type hue;
   rgb2hsv_pkg::sat_type saturation;
   rgb2hsv_pkg::val_type brightness;

   modport source (output valid, output hue, output saturation, output brightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input brightness,
                   output ready);
endinterface

@@ rtl/rgb_to_hsv_converter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_top
// Hexcone RGB to HSV conversion in fixed point. Saturation and hue come
// from two restoring dividers that retire one quotient bit per stage.
//
//   channel   dir   beat contents
//   req_bus   in    red, green, blue (8 bit each)
//   rsp_bus   out   hue (1/64 deg), saturation (1/65536), brightness
//
// One pixel per cycle while rsp_bus is not stalled. QW is the wider quotient
// width (17 with default parameters); it sets the number of divider stages.
// Reset clears all stage valid bits; payload registers are not reset.
// A result held on rsp_bus with ready low freezes the whole pipeline and
// drops req_bus ready in the same cycle.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top #(
   parameter int HUE_FRAC_BITS = 6,
   parameter int SAT_FRAC_BITS = 16
) (
   input logic                clock,
   input logic                reset,
   rgb2hsv_req_if.sink        req_bus,
   rgb2hsv_rsp_if.source      rsp_bus
);

   localparam int DW     = rgb2hsv_pkg::DEN_W;
   localparam int CW     = rgb2hsv_pkg::CH_W;
   localparam int TW     = rgb2hsv_pkg::TOP_W;
   localparam int HLIMIT = 360 << HUE_FRAC_BITS;
   localparam int HSCALE = 120 << HUE_FRAC_BITS;
   localparam int HQ_W   = $clog2(HLIMIT + 1);
   localparam int SQ_W   = SAT_FRAC_BITS + 1;
   localparam int QW     = (HQ_W > SQ_W) ? HQ_W : SQ_W;
   localparam int NW     = QW + DW;
   localparam int NST    = QW + 5;
   localparam int LAST   = NST - 1;

   typedef struct packed {
      logic [DW-1:0] rem_h;
      logic [DW-1:0] rem_s;
      logic [DW-1:0] den_h;
      logic [DW-1:0] den_s;
      logic [QW-1:0] low_h;
      logic [QW-1:0] low_s;
      logic [CW-1:0] mx;
      logic          hue_zero;
      logic          sat_zero;
   } div_type;

   function automatic div_type div_step(input div_type s);
      div_type       n;
      logic [DW:0]   trial_h;
      logic [DW:0]   trial_s;
      logic          ge_h;
      logic          ge_s;
      n       = s;
      trial_h = {s.rem_h, s.low_h[QW-1]};
      trial_s = {s.rem_s, s.low_s[QW-1]};
      ge_h    = trial_h >= {1'b0, s.den_h};
      ge_s    = trial_s >= {1'b0, s.den_s};
      n.rem_h = ge_h ? DW'(trial_h - {1'b0, s.den_h}) : trial_h[DW-1:0];
      n.rem_s = ge_s ? DW'(trial_s - {1'b0, s.den_s}) : trial_s[DW-1:0];
      n.low_h = {s.low_h[QW-2:0], ge_h};
      n.low_s = {s.low_s[QW-2:0], ge_s};
      return n;
   endfunction

   logic              en;
   logic [NST-1:0]    vld_ff;
   logic [NST-1:0]    vld_in;

   // stage 0: pixel
   logic [CW-1:0]     red_ff, green_ff, blue_ff;

   // stage 1: extremes and sector
   logic [CW-1:0]     s1_mx_ff, s1_mx_in;
   logic [CW-1:0]     s1_d_ff, s1_d_in;
   logic [CW-1:0]     s1_num_ff, s1_num_in;
   logic [rgb2hsv_pkg::BASE_W-1:0] s1_base_ff, s1_base_in;
   logic              s1_add_ff, s1_add_in;
   logic [CW-1:0]     mn;

   // stage 2: sector position numerator
   logic [TW-1:0]     s2_top_ff, s2_top_in;
   logic [CW-1:0]     s2_d_ff, s2_mx_ff;
   logic [TW-1:0]     base_d;

   // stages 3 .. QW+3: division
   div_type           div_ff [QW+1];
   div_type           div_in [QW+1];
   logic [NW-1:0]     num_h, num_s;

   // output stage
   rgb2hsv_pkg::hue_type hue_ff, hue_in;
   rgb2hsv_pkg::sat_type sat_ff, sat_in;
   rgb2hsv_pkg::val_type val_ff;
   logic [QW-1:0]     hue_c;

   assign en            = !vld_ff[LAST] || rsp_bus.ready;
   assign req_bus.ready = en;
   assign vld_in        = {vld_ff[NST-2:0], req_bus.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_comb begin
      s1_mx_in = red_ff;
      if (green_ff > s1_mx_in) s1_mx_in = green_ff;
      if (blue_ff > s1_mx_in) s1_mx_in = blue_ff;
      mn = red_ff;
      if (green_ff < mn) mn = green_ff;
      if (blue_ff < mn) mn = blue_ff;
      s1_d_in = s1_mx_in - mn;
      if (red_ff == s1_mx_in) begin
         if (green_ff == mn) begin
            s1_base_in = 3'd5; s1_add_in = 1'b1; s1_num_in = s1_mx_in - blue_ff;
         end else begin
            s1_base_in = 3'd1; s1_add_in = 1'b0; s1_num_in = s1_mx_in - green_ff;
         end
      end else if (green_ff == s1_mx_in) begin
         if (blue_ff == mn) begin
            s1_base_in = 3'd1; s1_add_in = 1'b1; s1_num_in = s1_mx_in - red_ff;
         end else begin
            s1_base_in = 3'd3; s1_add_in = 1'b0; s1_num_in = s1_mx_in - blue_ff;
         end
      end else if (red_ff == mn) begin
         s1_base_in = 3'd3; s1_add_in = 1'b1; s1_num_in = s1_mx_in - green_ff;
      end else begin
         s1_base_in = 3'd5; s1_add_in = 1'b0; s1_num_in = s1_mx_in - red_ff;
      end
   end

   always_comb begin
      base_d    = TW'(s1_base_ff) * TW'(s1_d_ff);
      s2_top_in = s1_add_ff ? (base_d + TW'(s1_num_ff)) : (base_d - TW'(s1_num_ff));
   end

   always_comb begin
      num_h = NW'(s2_top_ff) * NW'(HSCALE) + NW'(s2_d_ff);
      num_s = (NW'(s2_d_ff) << (SAT_FRAC_BITS + 1)) + NW'(s2_mx_ff);
      div_in[0].rem_h    = num_h[NW-1:QW];
      div_in[0].rem_s    = num_s[NW-1:QW];
      div_in[0].low_h    = num_h[QW-1:0];
      div_in[0].low_s    = num_s[QW-1:0];
      div_in[0].den_h    = {s2_d_ff, 1'b0};
      div_in[0].den_s    = {s2_mx_ff, 1'b0};
      div_in[0].mx       = s2_mx_ff;
      div_in[0].hue_zero = (s2_d_ff == '0);
      div_in[0].sat_zero = (s2_mx_ff == '0);
   end

   for (genvar j = 1; j <= QW; j++) begin : g_div
      assign div_in[j] = div_step(div_ff[j-1]);
   end

   always_comb begin
      hue_c  = (div_ff[QW].low_h > QW'(HLIMIT)) ? QW'(HLIMIT) : div_ff[QW].low_h;
      hue_in = div_ff[QW].hue_zero ? '0 : rgb2hsv_pkg::hue_type'(hue_c);
      sat_in = div_ff[QW].sat_zero ? '0 : rgb2hsv_pkg::sat_type'(div_ff[QW].low_s);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff     <= req_bus.red;
         green_ff   <= req_bus.green;
         blue_ff    <= req_bus.blue;
         s1_mx_ff   <= s1_mx_in;
         s1_d_ff    <= s1_d_in;
         s1_num_ff  <= s1_num_in;
         s1_base_ff <= s1_base_in;
         s1_add_ff  <= s1_add_in;
         s2_top_ff  <= s2_top_in;
         s2_d_ff    <= s1_d_ff;
         s2_mx_ff   <= s1_mx_ff;
         div_ff     <= div_in;
         hue_ff     <= hue_in;
         sat_ff     <= sat_in;
         val_ff     <= div_ff[QW].mx;
      end
   end

   assign rsp_bus.valid      = vld_ff[LAST];
   assign rsp_bus.hue        = hue_ff;
   assign rsp_bus.saturation = sat_ff;
   assign rsp_bus.brightness = val_ff;

endmodule

@@ rtl/rgb2hsv_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2hsv_checker
// Port-level checks of the RGB to HSV converter, bound to the top level.
// ----------------------------------------------------------------------------
module rgb2hsv_checker #(
   parameter int HUE_FRAC_BITS = 6
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input rgb2hsv_pkg::hue_type rsp_hue,
   input rgb2hsv_pkg::sat_type rsp_saturation,
   input rgb2hsv_pkg::val_type rsp_brightness
);

   localparam longint HLIMIT = 64'(360) << HUE_FRAC_BITS;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hue)
         && $stable(rsp_saturation) && $stable(rsp_brightness))
      else $error("stalled result beat changed");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 64'(rsp_hue) <= HLIMIT)
      else $error("hue above 360 degrees");

   a_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_brightness == '0 |-> rsp_hue == '0 && rsp_saturation == '0)
      else $error("black pixel with nonzero hue or saturation");

endmodule

bind rgb_to_hsv_converter_top rgb2hsv_checker #(
   .HUE_FRAC_BITS(HUE_FRAC_BITS)
) u_rgb2hsv_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_hue        (rsp_bus.hue),
   .rsp_saturation (rsp_bus.saturation),
   .rsp_brightness (rsp_bus.brightness)
);
